### src/uwd_pkg.sv
// Shared constants, types and helpers for the unimodular word decomposer.
`timescale 1ns / 1ps

package uwd_pkg;

    localparam int ENTRY_WIDTH = 32;
    localparam int MAX_WORD    = 64;
    localparam int CFG_W       = 7;
    localparam int CFG_RESET   = 64;
    localparam int CNT_W       = $clog2(MAX_WORD + 1);
    localparam int CMP_W       = (CFG_W > CNT_W) ? CFG_W : CNT_W;
    localparam int DIV_CNT_W   = $clog2(ENTRY_WIDTH);

    typedef logic signed [ENTRY_WIDTH-1:0] entry_t;
    typedef logic [ENTRY_WIDTH-1:0]        entry_mag_t;
    typedef logic [CFG_W-1:0]              cfg_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_DIVIDE,
        ST_EMIT
    } seq_state_t;

    typedef struct packed {
        logic   is_rotation;
        entry_t shear_amount;
        logic   last_letter;
        logic   word_empty;
        logic   word_truncated;
    } letter_t;

    // unsigned magnitude; the most negative value maps to 2^(W-1) without overflow
    function automatic entry_mag_t magnitude(input entry_t x);
        entry_mag_t m;
        begin
            m = x[ENTRY_WIDTH-1] ? entry_mag_t'(-x) : entry_mag_t'(x);
            return m;
        end
    endfunction

endpackage

### src/uwd_divider.sv
// Shared restoring divider on magnitudes, one quotient bit per cycle.
`timescale 1ns / 1ps

module uwd_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  uwd_pkg::entry_mag_t dividend,
    input  uwd_pkg::entry_mag_t divisor,
    output logic               done,
    output uwd_pkg::entry_mag_t quotient,
    output uwd_pkg::entry_mag_t remainder
);
    import uwd_pkg::*;

    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    entry_mag_t           rem_reg, rem_next;
    entry_mag_t           quo_reg, quo_next;
    entry_mag_t           div_reg, div_next;
    logic [ENTRY_WIDTH:0] trial;

    assign trial = {rem_reg, quo_reg[ENTRY_WIDTH-1]} - {1'b0, div_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = DIV_CNT_W'(ENTRY_WIDTH - 1);
            rem_next = '0;
            quo_next = dividend;
            div_next = divisor;
        end
        else if (run_reg)
        begin
            if (!trial[ENTRY_WIDTH])
            begin
                rem_next = trial[ENTRY_WIDTH-1:0];
                quo_next = {quo_reg[ENTRY_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[ENTRY_WIDTH-2:0], quo_reg[ENTRY_WIDTH-1]};
                quo_next = {quo_reg[ENTRY_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

### src/uwd_seq.sv
// Letter sequencer: working column, letter count and control of the shared divider.
`timescale 1ns / 1ps

module uwd_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  uwd_pkg::entry_t   top_entry,
    input  uwd_pkg::entry_t   bottom_entry,
    input  uwd_pkg::cfg_word_t max_letters,
    input  logic              out_free,
    output logic              push,
    output uwd_pkg::letter_t  letter
);
    import uwd_pkg::*;

    seq_state_t       state_reg, state_next;
    entry_t           top_reg, top_next;
    entry_t           bot_reg, bot_next;
    entry_t           k_reg, k_next;
    logic             rot_reg, rot_next;
    logic             empty_reg, empty_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] cap_reg, cap_next;
    logic [CNT_W-1:0] cnt_inc;
    logic [CMP_W-1:0] cap_raw;
    entry_mag_t       top_mag, bot_mag, div_quo, div_rem;
    logic             div_start, div_done, use_rot, word_end;

    uwd_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (top_mag),
        .divisor   (bot_mag),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign top_mag  = magnitude(top_reg);
    assign bot_mag  = magnitude(bot_reg);
    assign use_rot  = (top_reg == '0) || (top_mag < bot_mag);
    assign cnt_inc  = cnt_reg + CNT_W'(1);
    assign word_end = (cnt_inc == cap_reg) || (bot_reg == '0);
    assign cap_raw  = CMP_W'(max_letters);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_DECIDE;
            ST_DECIDE:
                if ((bot_reg == '0) || use_rot)
                    state_next = ST_EMIT;
                else
                    state_next = ST_DIVIDE;
            ST_DIVIDE:
                if (div_done)
                    state_next = ST_EMIT;
            ST_EMIT:
                if (out_free)
                    state_next = word_end ? ST_IDLE : ST_DECIDE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and strobes
    always_comb
    begin
        top_next   = top_reg;
        bot_next   = bot_reg;
        k_next     = k_reg;
        rot_next   = rot_reg;
        empty_next = empty_reg;
        cnt_next   = cnt_reg;
        cap_next   = cap_reg;
        div_start  = 1'b0;
        push       = 1'b0;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    top_next   = top_entry;
                    bot_next   = bottom_entry;
                    cnt_next   = '0;
                    empty_next = 1'b0;
                    if (cap_raw == '0)
                        cap_next = CNT_W'(1);
                    else if (cap_raw > CMP_W'(MAX_WORD))
                        cap_next = CNT_W'(MAX_WORD);
                    else
                        cap_next = CNT_W'(cap_raw);
                end
            ST_DECIDE:
                if (bot_reg == '0)
                begin
                    empty_next = 1'b1;
                    rot_next   = 1'b0;
                    k_next     = '0;
                end
                else if (use_rot)
                begin
                    rot_next = 1'b1;
                    k_next   = '0;
                    top_next = entry_t'(-bot_reg);
                    bot_next = top_reg;
                end
                else
                begin
                    rot_next  = 1'b0;
                    div_start = 1'b1;
                end
            ST_DIVIDE:
                if (div_done)
                begin
                    // remainder takes the dividend's sign; k is minus the quotient
                    top_next = top_reg[ENTRY_WIDTH-1] ? entry_t'(-div_rem) : entry_t'(div_rem);
                    k_next   = (top_reg[ENTRY_WIDTH-1] ^ bot_reg[ENTRY_WIDTH-1])
                             ? entry_t'(div_quo) : entry_t'(-div_quo);
                end
            ST_EMIT:
                if (out_free)
                begin
                    push     = 1'b1;
                    cnt_next = cnt_inc;
                end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        letter.is_rotation    = rot_reg;
        letter.shear_amount   = k_reg;
        letter.last_letter    = word_end;
        letter.word_empty     = empty_reg;
        letter.word_truncated = word_end && (bot_reg != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            cap_reg   <= CNT_W'(MAX_WORD);
            top_reg   <= '0;
            bot_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            cap_reg   <= cap_next;
            top_reg   <= top_next;
            bot_reg   <= bot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg     <= k_next;
        rot_reg   <= rot_next;
        empty_reg <= empty_next;
    end

endmodule

### src/unimodular_word_decomposer.sv
// Top level of the unimodular word decomposer: letter cap register and output register.
`timescale 1ns / 1ps

// Takes the first column (top_entry, bottom_entry) of a 2x2 integer matrix and
// runs Euclid on it, producing one output transfer per generator letter.
// Input channel: in_valid / in_stall; a transfer happens when valid is high and
// stall is low. in_stall is high from the cycle after a transfer until the last
// letter of that word has been handed to the output register.
// Output channel: out_valid / out_stall with is_rotation, shear_amount,
// last_letter, word_empty and word_truncated. last_letter marks the end of a
// word; an entry with bottom zero yields one transfer flagged word_empty.
// Config channel: cfg_valid / cfg_ready (always ready) writes max_letters, the
// letter cap (0 behaves as 1, values above 64 as 64); write it only when idle.
// Divider: one serial divider does every shear, one quotient bit a cycle, while a
// rotation letter or an empty word needs no division. Shears and rotations alternate.
// While out_stall is high the finished letter sits in the output register and
// the sequencer waits with the next letter; nothing is lost.
// Reset (rst_n low, asynchronous) returns to idle, drops out_valid and sets the
// cap back to 64.
module unimodular_word_decomposer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  uwd_pkg::entry_t    top_entry,
    input  uwd_pkg::entry_t    bottom_entry,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               is_rotation,
    output uwd_pkg::entry_t    shear_amount,
    output logic               last_letter,
    output logic               word_empty,
    output logic               word_truncated,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  uwd_pkg::cfg_word_t max_letters
);
    import uwd_pkg::*;

    cfg_word_t cap_cfg_reg, cap_cfg_next;
    logic      out_valid_reg, out_valid_next;
    letter_t   out_reg, out_next;
    letter_t   letter;
    logic      push, out_free;

    // output register is free when empty or being drained this cycle
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    uwd_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .top_entry    (top_entry),
        .bottom_entry (bottom_entry),
        .max_letters  (cap_cfg_reg),
        .out_free     (out_free),
        .push         (push),
        .letter       (letter)
    );

    always_comb
    begin
        cap_cfg_next = cap_cfg_reg;
        if (cfg_valid && cfg_ready)
            cap_cfg_next = max_letters;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
            out_next       = letter;
        end
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_cfg_reg   <= CFG_W'(CFG_RESET);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cap_cfg_reg   <= cap_cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid      = out_valid_reg;
    assign is_rotation    = out_reg.is_rotation;
    assign shear_amount   = out_reg.shear_amount;
    assign last_letter    = out_reg.last_letter;
    assign word_empty     = out_reg.word_empty;
    assign word_truncated = out_reg.word_truncated;

endmodule

### src/uwd_checker.sv
// Port-level checker for the unimodular word decomposer, bound to the top level.
`timescale 1ns / 1ps

module uwd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic               is_rotation,
    input uwd_pkg::entry_t    shear_amount,
    input logic               last_letter,
    input logic               word_empty,
    input logic               word_truncated
);
    import uwd_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output transfer withdrawn while stalled");

    // one input transfer starts a word, so the port stalls next cycle
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken twice in a row");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && word_empty |-> last_letter && !is_rotation && shear_amount == '0)
        else $error("empty word item malformed");

    a_trunc_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && word_truncated |-> last_letter && !word_empty)
        else $error("truncation flagged away from the last letter");

    a_rot_zero_shear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_rotation |-> shear_amount == '0 && !word_empty)
        else $error("rotation letter carries a shear amount");

endmodule

bind unimodular_word_decomposer uwd_checker u_uwd_checker (.*);

### test/unimodular_word_decomposer_tb.sv
// Self-checking testbench for the unimodular word decomposer, with a letter scoreboard.
`timescale 1ns / 1ps

// Stimulus and checking for unimodular_word_decomposer.
//
// Each accepted column (top, bottom) is run through a behavioural Euclid
// reduction held in the scoreboard. That reduction expands the column into
// the expected word of letters, which waits in a queue. Every output transfer
// is compared field by field against the oldest letter in the queue.
//
// The run is split into phases. The letter cap is rewritten between phases,
// and only once the queue has drained. Caps used: reset value 64, 1, 0
// (acts as 1), 2, 127 (acts as 64), 65, a few random mid values, then 64 again.
//
// Both channels idle in random bursts. The input side drops valid between
// columns, and the output side raises stall. The final phase runs with no
// idling at all.
module unimodular_word_decomposer_tb;

    import uwd_pkg::*;

    localparam int     HALF_PERIOD = 5;
    localparam int     RESET_CYCLES = 3;
    // Longest honest silence is one shear behind an output stall burst, plus
    // the short pauses between phases; this leaves ample margin.
    localparam int     STALL_LIMIT = 2000;
    localparam int     TAIL_CYCLES = 60;
    localparam int     MAX_PRINTED = 100;
    localparam entry_t MOST_NEG = entry_t'(32'h8000_0000);
    localparam entry_t MOST_POS = entry_t'(32'h7FFF_FFFF);

    // Expected-letter store plus the Euclid reduction that fills it.
    class word_scoreboard;
        letter_t     expected_letters[$];
        int unsigned cap_setting;
        int unsigned fail_count;
        int unsigned letters_seen;

        function new();
            cap_setting  = CFG_RESET;
            fail_count   = 0;
            letters_seen = 0;
        endfunction

        // Expand one accepted column into its word of letters.
        function void note_input(entry_t top, entry_t bottom);
            longint      t;
            longint      b;
            longint      q;
            longint      old_t;
            entry_t      wrapped;
            int unsigned limit;
            int unsigned n;
            letter_t     l;
            limit = (cap_setting == 0) ? 1 :
                    (cap_setting > MAX_WORD) ? MAX_WORD : cap_setting;
            t = top;
            b = bottom;
            if (b == 0)
            begin
                l = '0;
                l.last_letter = 1'b1;
                l.word_empty  = 1'b1;
                expected_letters.push_back(l);
                return;
            end
            n = 0;
            while (n < limit && b != 0)
            begin
                l = '0;
                if (t == 0 || (t < 0 ? -t : t) < (b < 0 ? -b : b))
                begin
                    // rotation: (t, b) -> (-b, t), negation wraps at entry width
                    old_t = t;
                    wrapped = entry_t'(-b);
                    t = wrapped;
                    b = old_t;
                    l.is_rotation = 1'b1;
                end
                else if (b == -1)
                begin
                    l.shear_amount = entry_t'(t);
                    t = 0;
                end
                else
                begin
                    q = t / b;
                    l.shear_amount = entry_t'(-q);
                    t = t % b;
                end
                n++;
                if (n == limit || b == 0)
                begin
                    l.last_letter    = 1'b1;
                    l.word_truncated = (b != 0);
                end
                expected_letters.push_back(l);
            end
        endfunction

        task report(string msg);
            if (fail_count < MAX_PRINTED)
                $display("[%0t] mismatch: %s", $realtime, msg);
            fail_count++;
        endtask

        task check_letter(letter_t got);
            letter_t want;
            letters_seen++;
            if (expected_letters.size() == 0)
            begin
                report($sformatf("letter %0d arrived with nothing expected", letters_seen));
                return;
            end
            want = expected_letters.pop_front();
            if (got.is_rotation !== want.is_rotation)
                report($sformatf("letter %0d is_rotation %b, want %b",
                                 letters_seen, got.is_rotation, want.is_rotation));
            if (got.shear_amount !== want.shear_amount)
                report($sformatf("letter %0d shear_amount %0d, want %0d",
                                 letters_seen, got.shear_amount, want.shear_amount));
            if (got.last_letter !== want.last_letter)
                report($sformatf("letter %0d last_letter %b, want %b",
                                 letters_seen, got.last_letter, want.last_letter));
            if (got.word_empty !== want.word_empty)
                report($sformatf("letter %0d word_empty %b, want %b",
                                 letters_seen, got.word_empty, want.word_empty));
            if (got.word_truncated !== want.word_truncated)
                report($sformatf("letter %0d word_truncated %b, want %b",
                                 letters_seen, got.word_truncated, want.word_truncated));
        endtask
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    entry_t    top_entry = '0;
    entry_t    bottom_entry = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    logic      is_rotation;
    entry_t    shear_amount;
    logic      last_letter;
    logic      word_empty;
    logic      word_truncated;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    cfg_word_t max_letters = cfg_word_t'(CFG_RESET);

    // No idling on either side once this is set.
    logic        quiet_tail = 1'b0;
    int unsigned silent_cycles = 0;
    letter_t     got_letter;

    word_scoreboard sb = new();

    unimodular_word_decomposer u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .top_entry      (top_entry),
        .bottom_entry   (bottom_entry),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .is_rotation    (is_rotation),
        .shear_amount   (shear_amount),
        .last_letter    (last_letter),
        .word_empty     (word_empty),
        .word_truncated (word_truncated),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .max_letters    (max_letters)
    );

    always #HALF_PERIOD clk = ~clk;

    // Monitor: everything is sampled at the rising edge, where the values
    // seen are the ones the block itself registers. The watchdog counts
    // cycles with no transfer on any channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_input(top_entry, bottom_entry);
            if (out_valid && !out_stall)
            begin
                got_letter = '{is_rotation, shear_amount, last_letter,
                               word_empty, word_truncated};
                sb.check_letter(got_letter);
            end
            if (cfg_valid && cfg_ready)
                sb.cap_setting = max_letters;
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            silent_cycles <= 0;
        else
            silent_cycles <= silent_cycles + 1;
        if (silent_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Output back-pressure: stall bursts that start at random, with clear
    // stretches between them.
    initial
    begin : stall_gen
        int burst;
        forever
        begin
            @(negedge clk);
            if (!quiet_tail && $urandom_range(0, 7) == 0)
            begin
                burst = $urandom_range(1, 12);
                out_stall <= 1'b1;
                repeat (burst) @(negedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // One column transfer, which may be preceded by a gap with valid low.
    // Valid drops at the falling edge after the transfer, while the block is
    // still busy, so a new column never replaces a stalled payload.
    task automatic send_column(entry_t top, entry_t bottom);
        int gap;
        gap = (!quiet_tail && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        top_entry    <= top;
        bottom_entry <= bottom;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Lower valid and wait until every expected letter has come out.
    task automatic drain_words();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_letters.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Drain the block, then write a new letter cap.
    task automatic set_letter_cap(int unsigned cap);
        drain_words();
        @(negedge clk);
        cfg_valid   <= 1'b1;
        max_letters <= cfg_word_t'(cap);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic entry_t random_entry();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return entry_t'($urandom);
            4, 5:       return entry_t'(int'($urandom_range(0, 40)) - 20);
            6:
            begin
                case ($urandom_range(0, 5))
                    0:       return MOST_NEG;
                    1:       return MOST_POS;
                    2:       return MOST_NEG + 1;
                    3:       return entry_t'(1);
                    4:       return entry_t'(-1);
                    default: return '0;
                endcase
            end
            default:    return entry_t'(int'($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    // Random columns; about one in eight is a pair of consecutive Fibonacci
    // numbers with random signs, which gives the longest words.
    task automatic run_random(int count);
        longint fa;
        longint fb;
        longint fc;
        int     steps;
        entry_t top;
        entry_t bottom;
        repeat (count)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                fa = 1;
                fb = 0;
                steps = $urandom_range(20, 45);
                repeat (steps)
                begin
                    fc = fa + fb;
                    fb = fa;
                    fa = fc;
                end
                top    = $urandom_range(0, 1) ? entry_t'(fa) : entry_t'(-fa);
                bottom = $urandom_range(0, 1) ? entry_t'(fb) : entry_t'(-fb);
            end
            else
            begin
                top    = random_entry();
                bottom = random_entry();
            end
            send_column(top, bottom);
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // Directed columns under the reset cap of 64.
        send_column(0, 0);                      // empty words
        send_column(5, 0);
        send_column(MOST_NEG, 0);
        send_column(0, 5);                      // top zero forces a rotation
        send_column(7, 3);
        send_column(3, 7);
        send_column(-7, 3);
        send_column(7, -3);
        send_column(-7, -3);
        send_column(1, 1);
        send_column(100, -1);                   // bottom of minus one
        send_column(MOST_NEG, -1);
        send_column(MOST_POS, -1);
        send_column(MOST_NEG, 1);               // shear amount wraps
        send_column(MOST_NEG, MOST_NEG);        // equal magnitudes take a shear
        send_column(1, MOST_NEG);               // negation of most negative
        send_column(MOST_NEG, 3);
        send_column(MOST_POS, MOST_POS);
        send_column(MOST_POS, MOST_NEG);
        send_column(1836311903, 1134903170);    // longer than the cap: truncated
        send_column(-1134903170, 701408733);
        send_column(12, -5);

        // Cap of one: a lone rotation that clears bottom is not truncated.
        set_letter_cap(1);
        send_column(0, 5);
        send_column(3, 7);
        send_column(0, 0);
        run_random(20);

        // Zero behaves as one.
        set_letter_cap(0);
        run_random(15);

        // Cap of two, reached exactly as bottom clears.
        set_letter_cap(2);
        send_column(1, 1);
        send_column(5, 5);
        run_random(15);

        // Above the word limit: clamped to 64.
        set_letter_cap(127);
        send_column(1836311903, 1134903170);
        run_random(25);

        set_letter_cap(65);
        run_random(15);

        repeat (3)
        begin
            set_letter_cap($urandom_range(3, 63));
            run_random(30);
        end

        // Final stretch at full cap with no idling on either side.
        set_letter_cap(64);
        quiet_tail = 1'b1;
        run_random(55);

        drain_words();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.fail_count == 0 && sb.expected_letters.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### filelist.f
src/uwd_pkg.sv
src/uwd_divider.sv
src/uwd_seq.sv
src/unimodular_word_decomposer.sv
src/uwd_checker.sv
test/unimodular_word_decomposer_tb.sv
